// ----- src/wtr_pkg.sv -----
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared types, constants and codes for the wrapping tilemap row renderer.
// ----------------------------------------------------------------------------
package wtr_pkg;

  // Map and tile geometry
  localparam int MAP_SIZE       = 64;
  localparam int MAP_BITS       = $clog2(MAP_SIZE);
  localparam int TILE_COUNT     = 16;
  localparam int TILE_BITS      = $clog2(TILE_COUNT);
  localparam int SCREEN_COLUMNS = 40;
  localparam int MAX_VIEW_WIDTH = 20;
  localparam int CNT_BITS       = $clog2(MAX_VIEW_WIDTH + 1);
  localparam int MAP_DEPTH      = MAP_SIZE * MAP_SIZE;
  localparam int MAP_ADDR_W     = 2 * MAP_BITS;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int CELL_W   = 6;
  localparam int TNUM_W   = 4;
  localparam int SLOT_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int STICK_W  = 4;
  localparam int ROW_W    = 4;
  localparam int ENTRY_W  = 4;
  localparam int ADDR_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;

  // Configuration register widths and reset values
  localparam int VCOL_W   = 6;
  localparam int VROW_W   = 5;
  localparam int VWIDTH_W = 5;
  localparam int VHEIGHT_W = 4;

  localparam logic [VCOL_W-1:0]    VIEW_COL_RST    = 6'd2;
  localparam logic [VROW_W-1:0]    VIEW_ROW_RST    = 5'd2;
  localparam logic [VWIDTH_W-1:0]  VIEW_WIDTH_RST  = 5'd10;
  localparam logic [VHEIGHT_W-1:0] VIEW_HEIGHT_RST = 4'd10;
  localparam logic [ADDR_W-1:0]    CHAR_BASE_RST   = 16'h0400;
  localparam logic [ADDR_W-1:0]    COLOR_BASE_RST  = 16'hD800;

  // APB port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_VIEW_COL    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_ROW    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CHAR_BASE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_BASE  = 3'd5;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_MAP_WR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TILE_WR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STICK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd3;

  // Joystick bits
  localparam int STICK_UP    = 0;
  localparam int STICK_DOWN  = 1;
  localparam int STICK_LEFT  = 2;
  localparam int STICK_RIGHT = 3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DRAW = 3'b010,
    S_JOY  = 3'b100
  } state_t;

  typedef struct packed {
    logic [VCOL_W-1:0]    view_col;
    logic [VROW_W-1:0]    view_row;
    logic [VWIDTH_W-1:0]  view_width;
    logic [VHEIGHT_W-1:0] view_height;
    logic [ADDR_W-1:0]    char_base;
    logic [ADDR_W-1:0]    color_base;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [TNUM_W-1:0]  tile_number;
    logic [SLOT_W-1:0]  tile_slot;
    logic [BYTE_W-1:0]  byte_value;
    logic [STICK_W-1:0] stick;
    logic [ROW_W-1:0]   draw_row;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  char_address;
    logic [ADDR_W-1:0]  color_address;
    logic [CHAR_W-1:0]  char_tl;
    logic [CHAR_W-1:0]  char_tr;
    logic [CHAR_W-1:0]  char_bl;
    logic [CHAR_W-1:0]  char_br;
    logic [COLOR_W-1:0] color_tl;
    logic [COLOR_W-1:0] color_tr;
    logic [COLOR_W-1:0] color_bl;
    logic [COLOR_W-1:0] color_br;
    logic               last;
    logic               moved;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic map_wr;
    logic tile_wr;
    logic joy_upd;
    logic load_joy;
    logic draw_start;
    logic issue;
    logic consume;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic joy_change;
    logic draw_ok;
    logic more_cols;
    logic last_col;
  } dp_stat_t;

endpackage

// ----- src/wtr_if.sv -----
// ----------------------------------------------------------------------------
// wtr_item_if / wtr_result_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface wtr_item_if;
  import wtr_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CELL_W-1:0]  cell_x;
  logic [CELL_W-1:0]  cell_y;
  logic [TNUM_W-1:0]  tile_number;
  logic [SLOT_W-1:0]  tile_slot;
  logic [BYTE_W-1:0]  byte_value;
  logic [STICK_W-1:0] stick;
  logic [ROW_W-1:0]   draw_row;

  modport source (
    output valid, kind, cell_x, cell_y, tile_number, tile_slot, byte_value, stick,
           draw_row,
    input  ready
  );
  modport sink (
    input  valid, kind, cell_x, cell_y, tile_number, tile_slot, byte_value, stick,
           draw_row,
    output ready
  );
endinterface

interface wtr_result_if;
  import wtr_pkg::*;

  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  char_address;
  logic [ADDR_W-1:0]  color_address;
  logic [CHAR_W-1:0]  char_tl;
  logic [CHAR_W-1:0]  char_tr;
  logic [CHAR_W-1:0]  char_bl;
  logic [CHAR_W-1:0]  char_br;
  logic [COLOR_W-1:0] color_tl;
  logic [COLOR_W-1:0] color_tr;
  logic [COLOR_W-1:0] color_bl;
  logic [COLOR_W-1:0] color_br;
  logic               last;
  logic               moved;

  modport source (
    output valid, char_address, color_address, char_tl, char_tr, char_bl, char_br,
           color_tl, color_tr, color_bl, color_br, last, moved,
    input  ready
  );
  modport sink (
    input  valid, char_address, color_address, char_tl, char_tr, char_bl, char_br,
           color_tl, color_tr, color_bl, color_br, last, moved,
    output ready
  );
endinterface

// ----- src/wtr_cfg.sv -----
// ----------------------------------------------------------------------------
// wtr_cfg
// APB register file holding the viewport geometry and base addresses.
// ----------------------------------------------------------------------------
module wtr_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wtr_pkg::PADDR_W-1:0]  paddr,
  input  logic [wtr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wtr_pkg::APB_DATA_W-1:0] prdata,
  output logic                         pready,
  output wtr_pkg::cfg_t                cfg
);
  import wtr_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_col    <= VIEW_COL_RST;
      cfg.view_row    <= VIEW_ROW_RST;
      cfg.view_width  <= VIEW_WIDTH_RST;
      cfg.view_height <= VIEW_HEIGHT_RST;
      cfg.char_base   <= CHAR_BASE_RST;
      cfg.color_base  <= COLOR_BASE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_VIEW_COL:    cfg.view_col    <= pwdata[VCOL_W-1:0];
        REG_VIEW_ROW:    cfg.view_row    <= pwdata[VROW_W-1:0];
        REG_VIEW_WIDTH:  cfg.view_width  <= pwdata[VWIDTH_W-1:0];
        REG_VIEW_HEIGHT: cfg.view_height <= pwdata[VHEIGHT_W-1:0];
        REG_CHAR_BASE:   cfg.char_base   <= pwdata[ADDR_W-1:0];
        REG_COLOR_BASE:  cfg.color_base  <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VIEW_COL:    prdata = APB_DATA_W'(cfg.view_col);
      REG_VIEW_ROW:    prdata = APB_DATA_W'(cfg.view_row);
      REG_VIEW_WIDTH:  prdata = APB_DATA_W'(cfg.view_width);
      REG_VIEW_HEIGHT: prdata = APB_DATA_W'(cfg.view_height);
      REG_CHAR_BASE:   prdata = APB_DATA_W'(cfg.char_base);
      REG_COLOR_BASE:  prdata = APB_DATA_W'(cfg.color_base);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- src/wtr_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtr_ctrl
// Sequencer: accepts transactions, walks a drawn row, owns the output valid.
// ----------------------------------------------------------------------------
module wtr_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [wtr_pkg::KIND_W-1:0] in_kind,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  wtr_pkg::dp_stat_t          stat,
  output wtr_pkg::dp_cmd_t           cmd
);
  import wtr_pkg::*;

  state_t state, state_next;
  logic   pending, pending_next;
  logic   out_valid_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    pending_next   = pending;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_MAP_WR:  cmd.map_wr  = 1'b1;
            KIND_TILE_WR: cmd.tile_wr = 1'b1;
            KIND_STICK: begin
              if (stat.joy_change) begin
                cmd.joy_upd = 1'b1;
                if (slot_free) begin
                  cmd.load_joy   = 1'b1;
                  out_valid_next = 1'b1;
                end else begin
                  state_next = S_JOY;
                end
              end
            end
            KIND_DRAW: begin
              if (stat.draw_ok) begin
                cmd.draw_start = 1'b1;
                pending_next   = 1'b0;
                state_next     = S_DRAW;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAW: begin
        // Keep one map read in flight ahead of the output register
        cmd.consume  = pending && slot_free;
        cmd.issue    = stat.more_cols && (!pending || cmd.consume);
        pending_next = cmd.issue || (pending && !cmd.consume);
        if (cmd.consume) begin
          out_valid_next = 1'b1;
          if (stat.last_col) state_next = S_IDLE;
        end
      end
      S_JOY: begin
        if (slot_free) begin
          cmd.load_joy   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/wtr_datapath.sv -----
// ----------------------------------------------------------------------------
// wtr_datapath
// Tile map memory, tile table, camera, row counters and output register.
// ----------------------------------------------------------------------------
module wtr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  wtr_pkg::dp_cmd_t   cmd,
  input  wtr_pkg::cfg_t      cfg,
  input  wtr_pkg::in_item_t  item,
  output wtr_pkg::dp_stat_t  stat,
  output wtr_pkg::result_t   res
);
  import wtr_pkg::*;

  logic [ENTRY_W-1:0]  map_mem [MAP_DEPTH];
  logic [CHAR_W-1:0]   tile_chars  [TILE_COUNT][4];
  logic [COLOR_W-1:0]  tile_colors [TILE_COUNT][4];

  logic [MAP_BITS-1:0] camera_x, camera_y;
  logic [STICK_W-1:0]  prev_stick;
  logic                joy_moved;

  logic [MAP_BITS-1:0] row_my;
  logic [CNT_BITS-1:0] col_issue, col_out, n_cols;
  logic [ADDR_W-1:0]   offset;
  logic [ENTRY_W-1:0]  map_q;

  logic [MAP_BITS-1:0]  issue_mx;
  logic [CNT_BITS-1:0]  n_sat;
  logic [TILE_BITS-1:0] tidx;
  logic                 moved_val;
  logic [ADDR_W-1:0]    origin;
  result_t              joy_res;

  assign issue_mx  = MAP_BITS'(camera_x + MAP_BITS'(col_issue));
  assign tidx      = map_q[TILE_BITS-1:0];
  assign moved_val = cmd.joy_upd ? (item.stick != '0) : joy_moved;
  assign n_sat     = (cfg.view_width > MAX_VIEW_WIDTH) ? CNT_BITS'(MAX_VIEW_WIDTH)
                                                       : CNT_BITS'(cfg.view_width);
  assign origin    = ADDR_W'(cfg.view_col)
                   + ADDR_W'(SCREEN_COLUMNS * cfg.view_row)
                   + ADDR_W'(SCREEN_COLUMNS * 2 * item.draw_row);

  assign stat.joy_change = (item.stick != prev_stick);
  assign stat.draw_ok    = (item.draw_row < cfg.view_height) && (cfg.view_width != '0);
  assign stat.more_cols  = (col_issue < n_cols);
  assign stat.last_col   = (CNT_BITS'(col_out + 1'b1) == n_cols);

  // Joystick answer: every field clear except moved
  always_comb begin
    joy_res       = '0;
    joy_res.moved = moved_val;
  end

  // Map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.map_wr) begin
      map_mem[{MAP_BITS'(item.cell_x), MAP_BITS'(item.cell_y)}] <= item.tile_number;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) map_q <= map_mem[{issue_mx, row_my}];
  end

  // Tile table
  always_ff @(posedge clk) begin
    if (cmd.tile_wr && (32'(item.tile_number) < TILE_COUNT)) begin
      if (!item.tile_slot[2]) begin
        tile_chars[item.tile_number[TILE_BITS-1:0]][item.tile_slot[1:0]] <= item.byte_value;
      end else begin
        tile_colors[item.tile_number[TILE_BITS-1:0]][item.tile_slot[1:0]] <=
          item.byte_value[COLOR_W-1:0];
      end
    end
  end

  // Camera and joystick history
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x   <= '0;
      camera_y   <= '0;
      prev_stick <= '0;
      joy_moved  <= 1'b0;
    end else if (cmd.joy_upd) begin
      prev_stick <= item.stick;
      joy_moved  <= (item.stick != '0);
      camera_x   <= MAP_BITS'(camera_x + MAP_BITS'(item.stick[STICK_RIGHT])
                              - MAP_BITS'(item.stick[STICK_LEFT]));
      camera_y   <= MAP_BITS'(camera_y + MAP_BITS'(item.stick[STICK_DOWN])
                              - MAP_BITS'(item.stick[STICK_UP]));
    end
  end

  // Row walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_issue <= '0;
      col_out   <= '0;
      n_cols    <= '0;
    end else if (cmd.draw_start) begin
      col_issue <= '0;
      col_out   <= '0;
      n_cols    <= n_sat;
    end else begin
      if (cmd.issue)   col_issue <= CNT_BITS'(col_issue + 1'b1);
      if (cmd.consume) col_out   <= CNT_BITS'(col_out + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      row_my <= MAP_BITS'(camera_y + MAP_BITS'(item.draw_row));
      offset <= origin;
    end else if (cmd.consume) begin
      offset <= ADDR_W'(offset + ADDR_W'(2));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_joy) begin
      res <= joy_res;
    end else if (cmd.consume) begin
      res.char_address  <= ADDR_W'(cfg.char_base + offset);
      res.color_address <= ADDR_W'(cfg.color_base + offset);
      res.char_tl       <= tile_chars[tidx][0];
      res.char_tr       <= tile_chars[tidx][1];
      res.char_bl       <= tile_chars[tidx][2];
      res.char_br       <= tile_chars[tidx][3];
      res.color_tl      <= tile_colors[tidx][0];
      res.color_tr      <= tile_colors[tidx][1];
      res.color_bl      <= tile_colors[tidx][2];
      res.color_br      <= tile_colors[tidx][3];
      res.last          <= stat.last_col;
      res.moved         <= 1'b0;
    end
  end

endmodule

// ----- src/wrapping_tilemap_row_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// wrapping_tilemap_row_renderer_unit
// Scrolls a viewport over a wrapping 64x64 map of 2x2-character tiles.
// ----------------------------------------------------------------------------
//
//  channel   role    handshake              carries
//  -------   ------  ---------------------  ----------------------------------
//  items     sink    valid/ready            map write, tile byte, stick, draw
//  results   source  valid/ready            tile addresses, chars, colors
//  apb       slave   psel/penable, pready=1 viewport and base registers
//
//  Map writes, tile byte writes and joystick samples are taken while idle;
//  a joystick answer waits in place while the previous result is stalled.
//  A drawn row of n tiles holds the item port: the accept, one map memory
//  read ahead, then one result per cycle while results are not stalled,
//  with one read kept in flight ahead of the output register.
//  Reset (rst, synchronous) clears the camera, the stick history and all
//  valids, resets the APB registers; map and tile storage start undefined.
//  A stalled result holds the row walk; items wait while a row is drawn.
//
module wrapping_tilemap_row_renderer_unit (
  input  logic                           clk,
  input  logic                           rst,
  wtr_item_if.sink                       items,
  wtr_result_if.source                   results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wtr_pkg::PADDR_W-1:0]    paddr,
  input  logic [wtr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wtr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import wtr_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  in_item_t item;
  result_t  res;
  logic     in_ready;
  logic     out_valid;

  // Gather the request payload for the datapath
  assign item.cell_x      = items.cell_x;
  assign item.cell_y      = items.cell_y;
  assign item.tile_number = items.tile_number;
  assign item.tile_slot   = items.tile_slot;
  assign item.byte_value  = items.byte_value;
  assign item.stick       = items.stick;
  assign item.draw_row    = items.draw_row;
  assign items.ready      = in_ready;

  wtr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: decides what moves each cycle
  wtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_kind   (items.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, camera and output register
  wtr_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .cfg  (cfg),
    .item (item),
    .stat (stat),
    .res  (res)
  );

  // Drive the result channel from the output register
  assign results.valid         = out_valid;
  assign results.char_address  = res.char_address;
  assign results.color_address = res.color_address;
  assign results.char_tl       = res.char_tl;
  assign results.char_tr       = res.char_tr;
  assign results.char_bl       = res.char_bl;
  assign results.char_br       = res.char_br;
  assign results.color_tl      = res.color_tl;
  assign results.color_tr      = res.color_tr;
  assign results.color_bl      = res.color_bl;
  assign results.color_br      = res.color_br;
  assign results.last          = res.last;
  assign results.moved         = res.moved;

endmodule

// ----- src/wtr_checker.sv -----
// ----------------------------------------------------------------------------
// wtr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wtr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wtr_pkg::ADDR_W-1:0]  char_address,
  input logic [wtr_pkg::ADDR_W-1:0]  color_address,
  input logic [wtr_pkg::COLOR_W-1:0] color_tl,
  input logic                        last,
  input logic                        moved
);
  import wtr_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_hold_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(char_address) && $stable(color_address))
    else $error("result address changed while stalled");

  a_moved_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && moved |-> char_address == '0 && color_address == '0
                           && color_tl == '0 && !last)
    else $error("joystick result carries draw fields");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind wrapping_tilemap_row_renderer_unit wtr_checker u_wtr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .char_address  (results.char_address),
  .color_address (results.color_address),
  .color_tl      (results.color_tl),
  .last          (results.last),
  .moved         (results.moved)
);
